// File: sv/pfde_pkg.sv
// Shared types, constants and helper functions of the paged framebuffer draw engine.
`timescale 1ns / 1ps
package pfde_pkg;

   localparam int WIDTH    = 128;
   localparam int HEIGHT   = 64;
   localparam int PAGES    = (HEIGHT + 7) / 8;
   localparam int VIEW_LIM = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
   localparam int DEPTH    = WIDTH * PAGES;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam int COORD_W  = 18;
   localparam int ACC_W    = 20;
   localparam int R_W      = 12;
   localparam int SQ_W     = 2 * R_W;

   localparam logic [2:0] MODE_CLEAR  = 3'd0;
   localparam logic [2:0] MODE_POINT  = 3'd1;
   localparam logic [2:0] MODE_LINE   = 3'd2;
   localparam logic [2:0] MODE_RECT   = 3'd3;
   localparam logic [2:0] MODE_CIRCLE = 3'd4;
   localparam logic [2:0] MODE_READ   = 3'd5;
   localparam logic [2:0] MODE_MASK   = 3'd6;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_CLEAR, ST_READ, ST_READ_WAIT, ST_MASK, ST_FINISH,
      ST_PLOT, ST_PLOT_WR,
      ST_LINE_SETUP, ST_LINE_PLOT, ST_LINE_STEP,
      ST_RECT_SETUP, ST_RECT_FILL, ST_RECT_FSTEP, ST_RECT_ROW, ST_RECT_RSTEP,
      ST_RECT_COL, ST_RECT_CSTEP,
      ST_CIRC_TEST, ST_CIRC_SQRT, ST_CIRC_OUT, ST_CIRC_OSTEP, ST_CIRC_FSET,
      ST_CIRC_FILL, ST_CIRC_FSTEP
   } state_type;

   typedef struct packed {
      logic              done;
      logic [R_W-1:0]    root;
      logic [R_W:0]      rem;
   } sqrt_result_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        mask;
      logic [PG_W-1:0]   page;
   } plot_target_type;

   function automatic coord_type cmax(input coord_type a, input coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic coord_type cmin(input coord_type a, input coord_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// File: sv/paged_framebuffer_draw_engine.sv
// Top level: command sequencer, shape generators and framebuffer of the draw engine.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; busy then stays high until
// the command is done, and the result appears on the rsp_ ports for exactly one cycle
// with rsp_valid high, so the receiver must take it then. Every plotted pixel is a
// read-modify-write on the single framebuffer RAM. A circle runs the twelve-pass
// square root unit once per row before it plots that row's points. Clear walks all
// 1024 bytes, one per cycle; after reset the same walk zeroes the store, so busy is
// high until that walk is done.
module paged_framebuffer_draw_engine import pfde_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_x_start,
   input  logic signed [15:0] req_y_start,
   input  logic signed [15:0] req_x_end,
   input  logic signed [15:0] req_y_end,
   input  logic [11:0]        req_radius,
   input  logic               req_fill,
   input  logic               req_color,
   input  logic [7:0]         req_fill_byte,
   input  logic [2:0]         req_page,
   input  logic [6:0]         req_column,
   output logic               rsp_valid,
   output logic [7:0]         rsp_read_byte,
   output logic [7:0]         rsp_dirty_mask,
   input  logic               csr_we,
   input  logic [1:0]         csr_wdata
);

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [1:0]         rot_ff, rot_in;
   logic signed [15:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [11:0]        rad_ff, rad_in;
   logic               fill_ff, fill_in, color_ff, color_in;
   logic [7:0]         fb_ff, fb_in;
   logic [2:0]         pg_ff, pg_in;
   logic [6:0]         col_ff, col_in;
   logic [7:0]         byte_ff, byte_in, mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in, rsp_mask_ff, rsp_mask_in;
   logic [PAGES-1:0]   dirty_ff, dirty_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   coord_type          pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [ADDR_W-1:0]  paddr_ff, paddr_in;
   logic [7:0]         pbit_ff, pbit_in;
   logic [PG_W-1:0]    ppage_ff, ppage_in;
   coord_type          i_ff, i_in, j_ff, j_in, lend_ff, lend_in, lq_ff, lq_in;
   logic               lneg_ff, lneg_in, lmaj_ff, lmaj_in;
   acc_type            lr_ff, lr_in, linc_ff, linc_in, ltwod_ff, ltwod_in;
   coord_type          xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;
   coord_type          jhi_ff, jhi_in, jlim_ff, jlim_in;
   logic [2:0]         k_ff, k_in;
   logic               sw_ff, sw_in, run_ff, run_in;

   // RAM and helper units
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;
   plot_target_type   target;
   logic              sq_start;
   logic [SQ_W-1:0]   sq_value;
   sqrt_result_type   sq_result;

   // Shared conditions
   coord_type cxs, cys, cxe, cye, dx, dy, adx, ady, den, num, aden, lqt;
   logic      line_dot, line_major, line_last;
   acc_type   rt;
   coord_type x1, x2, y1, y2, vl_max;
   logic [12:0] ci;
   logic      circ_stop;
   coord_type new_jlim, fa, fc, ap, am, run_lo, run_hi;
   logic      fill_skip, sweep_last, read_ok;
   coord_type pa, pc, pj, pu, pv;
   logic      pswap;

   pfde_ram #(.DATA_W(8), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pfde_plot_map u_map (
      .x      (pt_x_ff),
      .y      (pt_y_ff),
      .rot    (rot_ff),
      .target (target)
   );

   pfde_isqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .value  (sq_value),
      .result (sq_result)
   );

   always_comb begin
      cxs = COORD_W'(xs_ff);
      cys = COORD_W'(ys_ff);
      cxe = COORD_W'(xe_ff);
      cye = COORD_W'(ye_ff);
      vl_max = coord_type'(VIEW_LIM - 1);

      dx = cxe - cxs;
      dy = cye - cys;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      line_dot   = (dx == 0) && (dy == 0);
      line_major = adx > ady;
      den  = line_major ? dx : dy;
      num  = line_major ? dy : dx;
      aden = (den < 0) ? -den : den;
      // Floor quotient plus remainder give the truncated value toward zero.
      lqt = lq_ff + (((lq_ff < 0) && (lr_ff != 0)) ? coord_type'(1) : coord_type'(0));
      line_last = (i_ff == lend_ff);
      rt = lr_ff + linc_ff;

      x1 = (cxs > cxe) ? cxe : cxs;
      x2 = (cxs > cxe) ? cxs : cxe;
      y1 = (cys > cye) ? cye : cys;
      y2 = (cys > cye) ? cys : cye;

      ci = i_ff[12:0];
      circ_stop = (21'(ci) * 21'(100)) > (21'(rad_ff) * 21'(71));
      sq_value  = 24'(rad_ff) * 24'(rad_ff) - 24'(ci) * 24'(ci);
      new_jlim  = coord_type'(sq_result.root)
                + ((sq_result.rem > {1'b0, sq_result.root}) ? coord_type'(1)
                                                           : coord_type'(0));

      fa = sw_ff ? cys : cxs;
      fc = sw_ff ? cxs : cys;
      ap = fa + i_ff;
      am = fa - i_ff;
      fill_skip = ((ap < 0) || (ap > vl_max)) && ((am < 0) || (am > vl_max));
      if (!run_ff) begin
         run_lo = cmax(coord_type'(0), -fc);
         run_hi = cmin(jlim_ff, vl_max - fc);
      end else begin
         run_lo = cmax(coord_type'(0), fc - vl_max);
         run_hi = cmin(jlim_ff, fc);
      end

      // One of the eight mirrored points around the circle center.
      if (state_ff == ST_CIRC_OUT) begin
         pa    = k_ff[2] ? cys : cxs;
         pc    = k_ff[2] ? cxs : cys;
         pj    = jlim_ff;
         pswap = k_ff[2];
      end else begin
         pa    = fa;
         pc    = fc;
         pj    = j_ff;
         pswap = sw_ff;
      end
      pu = k_ff[1] ? (pa - i_ff) : (pa + i_ff);
      pv = k_ff[0] ? (pc - pj) : (pc + pj);

      sweep_last = (sweep_ff == ADDR_W'(DEPTH - 1));
      read_ok    = (int'(pg_ff) < PAGES) && (int'(col_ff) < WIDTH);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (sweep_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_CLEAR:  state_in = ST_CLEAR;
                  MODE_POINT:  state_in = ST_PLOT;
                  MODE_LINE:   state_in = ST_LINE_SETUP;
                  MODE_RECT:   state_in = ST_RECT_SETUP;
                  MODE_CIRCLE: state_in = ST_CIRC_TEST;
                  MODE_READ:   state_in = ST_READ;
                  MODE_MASK:   state_in = ST_MASK;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR:     if (sweep_last) state_in = ST_FINISH;
         ST_READ:      state_in = read_ok ? ST_READ_WAIT : ST_FINISH;
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_MASK:      state_in = ST_FINISH;
         ST_FINISH:    state_in = ST_IDLE;
         ST_PLOT:      state_in = target.valid ? ST_PLOT_WR : ret_ff;
         ST_PLOT_WR:   state_in = ret_ff;
         ST_LINE_SETUP: state_in = ST_PLOT;
         ST_LINE_PLOT:  state_in = ST_PLOT;
         ST_LINE_STEP:  state_in = line_last ? ST_FINISH : ST_LINE_PLOT;
         ST_RECT_SETUP: state_in = fill_ff ? ST_RECT_FILL : ST_RECT_ROW;
         ST_RECT_FILL: begin
            state_in = ((i_ff > xhi_ff) || (ylo_ff > yhi_ff)) ? ST_FINISH : ST_PLOT;
         end
         ST_RECT_FSTEP: state_in = ST_RECT_FILL;
         ST_RECT_ROW:   state_in = (i_ff > xhi_ff) ? ST_RECT_COL : ST_PLOT;
         ST_RECT_RSTEP: state_in = ST_RECT_ROW;
         ST_RECT_COL:   state_in = (i_ff > yhi_ff) ? ST_FINISH : ST_PLOT;
         ST_RECT_CSTEP: state_in = ST_RECT_COL;
         ST_CIRC_TEST:  state_in = circ_stop ? ST_FINISH : ST_CIRC_SQRT;
         ST_CIRC_SQRT: begin
            if (sq_result.done) state_in = fill_ff ? ST_CIRC_FSET : ST_CIRC_OUT;
         end
         ST_CIRC_OUT:   state_in = ST_PLOT;
         ST_CIRC_OSTEP: state_in = (k_ff == 3'd7) ? ST_CIRC_TEST : ST_CIRC_OUT;
         ST_CIRC_FSET: begin
            if (fill_skip) state_in = sw_ff ? ST_CIRC_TEST : ST_CIRC_FSET;
            else state_in = ST_CIRC_FILL;
         end
         ST_CIRC_FILL: begin
            if (j_ff > jhi_ff) state_in = (run_ff && sw_ff) ? ST_CIRC_TEST : ST_CIRC_FSET;
            else state_in = ST_PLOT;
         end
         ST_CIRC_FSTEP: state_in = ST_CIRC_FILL;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs
   always_comb begin
      ret_in = ret_ff;
      rot_in = csr_we ? csr_wdata : rot_ff;
      xs_in = xs_ff; ys_in = ys_ff; xe_in = xe_ff; ye_in = ye_ff;
      rad_in = rad_ff; fill_in = fill_ff; color_in = color_ff; fb_in = fb_ff;
      pg_in = pg_ff; col_in = col_ff; byte_in = byte_ff; mask_in = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_mask_in  = rsp_mask_ff;
      dirty_in = dirty_ff;
      sweep_in = sweep_ff;
      pt_x_in = pt_x_ff; pt_y_in = pt_y_ff;
      paddr_in = paddr_ff; pbit_in = pbit_ff; ppage_in = ppage_ff;
      i_in = i_ff; j_in = j_ff; lend_in = lend_ff; lq_in = lq_ff;
      lneg_in = lneg_ff; lmaj_in = lmaj_ff;
      lr_in = lr_ff; linc_in = linc_ff; ltwod_in = ltwod_ff;
      xlo_in = xlo_ff; xhi_in = xhi_ff; ylo_in = ylo_ff; yhi_in = yhi_ff;
      jhi_in = jhi_ff; jlim_in = jlim_ff;
      k_in = k_ff; sw_in = sw_ff; run_in = run_ff;
      ram_we = 1'b0;
      ram_waddr = paddr_ff;
      ram_wdata = '0;
      ram_raddr = '0;
      sq_start = 1'b0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = (state_ff == ST_CLEAR) ? fb_ff : 8'h00;
            sweep_in  = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
            if (state_ff == ST_CLEAR && sweep_last) dirty_in = '1;
         end
         ST_IDLE: begin
            if (start) begin
               xs_in = req_x_start; ys_in = req_y_start;
               xe_in = req_x_end;   ye_in = req_y_end;
               rad_in = req_radius; fill_in = req_fill; color_in = req_color;
               fb_in = req_fill_byte; pg_in = req_page; col_in = req_column;
               byte_in = '0;
               mask_in = '0;
               pt_x_in = COORD_W'(req_x_start);
               pt_y_in = COORD_W'(req_y_start);
               ret_in  = ST_FINISH;
               i_in    = '0;
            end
         end
         ST_READ: begin
            ram_raddr = ADDR_W'(int'(pg_ff) * WIDTH + int'(col_ff));
         end
         ST_READ_WAIT: byte_in = ram_rdata;
         ST_MASK: begin
            mask_in  = 8'(dirty_ff);
            dirty_in = '0;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = byte_ff;
            rsp_mask_in  = mask_ff;
         end
         ST_PLOT: begin
            ram_raddr = target.addr;
            paddr_in  = target.addr;
            pbit_in   = target.mask;
            ppage_in  = target.page;
         end
         ST_PLOT_WR: begin
            ram_wdata = color_ff ? (ram_rdata | pbit_ff) : (ram_rdata & ~pbit_ff);
            if (ram_wdata != ram_rdata) begin
               ram_we = 1'b1;
               dirty_in[ppage_ff] = 1'b1;
            end
         end
         ST_LINE_SETUP: begin
            // The first minor coordinate is base plus one half, truncated toward zero.
            pt_x_in  = (!line_dot && !line_major && (cxs < 0)) ? cxs + coord_type'(1)
                                                               : cxs;
            pt_y_in  = (!line_dot && line_major && (cys < 0)) ? cys + coord_type'(1)
                                                              : cys;
            ret_in   = line_dot ? ST_FINISH : ST_LINE_STEP;
            lmaj_in  = line_major;
            lneg_in  = den < 0;
            i_in     = line_major ? cxs : cys;
            lend_in  = line_major ? cxe : cye;
            // At the start point the floor value is the base and the remainder is D.
            lq_in    = line_major ? cys : cxs;
            lr_in    = acc_type'(aden);
            ltwod_in = acc_type'(aden) + acc_type'(aden);
            linc_in  = acc_type'(num) + acc_type'(num);
         end
         ST_LINE_PLOT: begin
            pt_x_in = lmaj_ff ? i_ff : lqt;
            pt_y_in = lmaj_ff ? lqt : i_ff;
            ret_in  = ST_LINE_STEP;
         end
         ST_LINE_STEP: begin
            if (!line_last) begin
               i_in = lneg_ff ? (i_ff - coord_type'(1)) : (i_ff + coord_type'(1));
               if (rt >= ltwod_ff) begin
                  lr_in = rt - ltwod_ff;
                  lq_in = lq_ff + coord_type'(1);
               end else if (rt < 0) begin
                  lr_in = rt + ltwod_ff;
                  lq_in = lq_ff - coord_type'(1);
               end else begin
                  lr_in = rt;
               end
            end
         end
         ST_RECT_SETUP: begin
            xs_in = x1[15:0]; xe_in = x2[15:0];
            ys_in = y1[15:0]; ye_in = y2[15:0];
            xlo_in = cmax(coord_type'(0), x1);
            xhi_in = cmin(vl_max, x2);
            ylo_in = cmax(coord_type'(0), y1);
            yhi_in = cmin(vl_max, y2);
            i_in = cmax(coord_type'(0), x1);
            j_in = cmax(coord_type'(0), y1);
            k_in = '0;
         end
         ST_RECT_FILL: begin
            pt_x_in = i_ff;
            pt_y_in = j_ff;
            ret_in  = ST_RECT_FSTEP;
         end
         ST_RECT_FSTEP: begin
            if (j_ff >= yhi_ff) begin
               j_in = ylo_ff;
               i_in = i_ff + coord_type'(1);
            end else begin
               j_in = j_ff + coord_type'(1);
            end
         end
         ST_RECT_ROW: begin
            if (i_ff > xhi_ff) begin
               i_in = ylo_ff;
               k_in = '0;
            end
            pt_x_in = i_ff;
            pt_y_in = k_ff[0] ? cye : cys;
            ret_in  = ST_RECT_RSTEP;
         end
         ST_RECT_RSTEP, ST_RECT_CSTEP: begin
            k_in = {2'b00, ~k_ff[0]};
            if (k_ff[0]) i_in = i_ff + coord_type'(1);
         end
         ST_RECT_COL: begin
            pt_x_in = k_ff[0] ? cxe : cxs;
            pt_y_in = i_ff;
            ret_in  = ST_RECT_CSTEP;
         end
         ST_CIRC_TEST: sq_start = !circ_stop;
         ST_CIRC_SQRT: begin
            jlim_in = new_jlim;
            k_in    = '0;
            sw_in   = 1'b0;
            run_in  = 1'b0;
         end
         ST_CIRC_OUT, ST_CIRC_FILL: begin
            pt_x_in = pswap ? pv : pu;
            pt_y_in = pswap ? pu : pv;
            ret_in  = (state_ff == ST_CIRC_OUT) ? ST_CIRC_OSTEP : ST_CIRC_FSTEP;
            if (state_ff == ST_CIRC_FILL && j_ff > jhi_ff) begin
               if (!run_ff) begin
                  run_in = 1'b1;
               end else if (!sw_ff) begin
                  sw_in  = 1'b1;
                  run_in = 1'b0;
               end else begin
                  i_in = i_ff + coord_type'(1);
               end
            end
         end
         ST_CIRC_OSTEP: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd7) i_in = i_ff + coord_type'(1);
         end
         ST_CIRC_FSET: begin
            if (fill_skip) begin
               if (sw_ff) begin
                  i_in = i_ff + coord_type'(1);
               end else begin
                  sw_in  = 1'b1;
                  run_in = 1'b0;
               end
            end else begin
               j_in   = run_lo;
               jhi_in = run_hi;
               k_in   = '0;
            end
         end
         ST_CIRC_FSTEP: begin
            if (k_ff[1:0] == 2'd3) begin
               k_in = '0;
               j_in = j_ff + coord_type'(1);
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         default: begin
            ret_in = ret_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rot_ff       <= ROT_0;
         dirty_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         dirty_ff     <= dirty_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff <= ret_in;
      xs_ff <= xs_in; ys_ff <= ys_in; xe_ff <= xe_in; ye_ff <= ye_in;
      rad_ff <= rad_in; fill_ff <= fill_in; color_ff <= color_in; fb_ff <= fb_in;
      pg_ff <= pg_in; col_ff <= col_in; byte_ff <= byte_in; mask_ff <= mask_in;
      rsp_byte_ff <= rsp_byte_in; rsp_mask_ff <= rsp_mask_in;
      pt_x_ff <= pt_x_in; pt_y_ff <= pt_y_in;
      paddr_ff <= paddr_in; pbit_ff <= pbit_in; ppage_ff <= ppage_in;
      i_ff <= i_in; j_ff <= j_in; lend_ff <= lend_in; lq_ff <= lq_in;
      lneg_ff <= lneg_in; lmaj_ff <= lmaj_in;
      lr_ff <= lr_in; linc_ff <= linc_in; ltwod_ff <= ltwod_in;
      xlo_ff <= xlo_in; xhi_ff <= xhi_in; ylo_ff <= ylo_in; yhi_ff <= yhi_in;
      jhi_ff <= jhi_in; jlim_ff <= jlim_in;
      k_ff <= k_in; sw_ff <= sw_in; run_ff <= run_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_dirty_mask = rsp_mask_ff;

endmodule

// File: sv/pfde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfde_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/pfde_isqrt.sv
// Iterative integer square root over one add and compare, refining the root bit by bit.
`timescale 1ns / 1ps
module pfde_isqrt import pfde_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] value,
   output sqrt_result_type result
);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0] res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   sum;

   always_comb begin
      sum     = {1'b0, res_ff} + {1'b0, bit_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         run_in = 1'b1;
         v_in   = value;
         res_in = '0;
         bit_in = SQ_W'(1) << (SQ_W - 2);
      end else if (run_ff) begin
         if ({1'b0, v_ff} >= sum) begin
            v_in   = v_ff - sum[SQ_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQ_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign result.done = done_ff;
   assign result.root = res_ff[R_W-1:0];
   assign result.rem  = v_ff[R_W:0];

endmodule

// File: sv/pfde_plot_map.sv
// Rotation, clipping and page addressing of one plotted point.
`timescale 1ns / 1ps
module pfde_plot_map import pfde_pkg::*; (
   input  coord_type       x,
   input  coord_type       y,
   input  logic [1:0]      rot,
   output plot_target_type target
);

   always_comb begin
      int  xi;
      int  yi;
      int  px;
      int  py;
      logic inside_view;
      xi = int'(x);
      yi = int'(y);
      px = 0;
      py = 0;
      inside_view = 1'b0;
      unique case (rot)
         ROT_0: begin
            inside_view = (xi < WIDTH) && (yi < HEIGHT);
            px = xi;
            py = yi;
         end
         ROT_90: begin
            inside_view = (xi < HEIGHT) && (yi < WIDTH);
            px = WIDTH - 1 - yi;
            py = xi;
         end
         ROT_180: begin
            inside_view = (xi < WIDTH) && (yi < HEIGHT);
            px = WIDTH - 1 - xi;
            py = HEIGHT - 1 - yi;
         end
         ROT_270: begin
            inside_view = (xi < HEIGHT) && (yi < WIDTH);
            px = yi;
            py = HEIGHT - 1 - xi;
         end
         default: begin
            inside_view = 1'b0;
         end
      endcase
      target.valid = inside_view && (xi >= 0) && (yi >= 0);
      target.addr  = ADDR_W'((py >> 3) * WIDTH + px);
      target.mask  = 8'(1 << (py & 7));
      target.page  = PG_W'(py >> 3);
   end

endmodule

// File: sv/pfde_checker.sv
// Port-level checks of the draw engine's command and result timing, bound to the top level.
`timescale 1ns / 1ps
module pfde_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [7:0]         rsp_read_byte,
   input logic [7:0]         rsp_dirty_mask
);

   // An accepted command always occupies the engine in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after a command transfer");

   // A result is only delivered as the engine returns to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a command");

   // One command yields one result: the strobe is never high in consecutive cycles.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // Read byte and dirty mask come from different commands.
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_dirty_mask != 8'h00)) |-> (rsp_read_byte == 8'h00))
      else $error("read byte and dirty mask both nonzero");

endmodule

bind paged_framebuffer_draw_engine pfde_checker u_pfde_checker (.*);

// File: bench/paged_framebuffer_draw_engine_test.sv
// Self-checking testbench for the paged framebuffer draw engine: directed rows, then random drawing.
`timescale 1ns / 1ps
module paged_framebuffer_draw_engine_test;
   import pfde_pkg::*;

   localparam int LIMIT_CYCLES = 20000000;

   typedef struct {
      logic [2:0]         mode;
      logic signed [15:0] xs, ys, xe, ye;
      logic [11:0]        radius;
      logic               fill, color;
      logic [7:0]         fill_byte;
      logic [2:0]         page;
      logic [6:0]         column;
      bit                 known;
      logic [7:0]         known_byte, known_mask;
   } draw_cmd_t;

   typedef struct {
      logic [7:0] read_byte;
      logic [7:0] dirty_mask;
   } readback_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_mode = '0;
   logic signed [15:0] req_x_start = '0, req_y_start = '0, req_x_end = '0, req_y_end = '0;
   logic [11:0] req_radius = '0;
   logic req_fill = 0, req_color = 0;
   logic [7:0] req_fill_byte = '0;
   logic [2:0] req_page = '0;
   logic [6:0] req_column = '0;
   logic rsp_valid;
   logic [7:0] rsp_read_byte, rsp_dirty_mask;
   logic csr_we = 0;
   logic [1:0] csr_wdata = '0;

   // Shadow copy of the screen the engine should be holding.
   logic [7:0] shadow_fb[DEPTH];
   logic [7:0] shadow_dirty;
   logic [1:0] shadow_rot;

   readback_t readback_queue[$];
   int errors = 0;
   int cycles = 0;

   paged_framebuffer_draw_engine DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      readback_t exp_rsp;
      if (!reset && rsp_valid) begin
         if (readback_queue.size() == 0) begin
            $display("%0t: unexpected transfer byte=%h mask=%h", $time, rsp_read_byte,
                     rsp_dirty_mask);
            errors++;
         end else begin
            exp_rsp = readback_queue.pop_front();
            if (rsp_read_byte !== exp_rsp.read_byte) begin
               $display("%0t: read_byte expected %h actual %h", $time, exp_rsp.read_byte,
                        rsp_read_byte);
               errors++;
            end
            if (rsp_dirty_mask !== exp_rsp.dirty_mask) begin
               $display("%0t: dirty_mask expected %h actual %h", $time, exp_rsp.dirty_mask,
                        rsp_dirty_mask);
               errors++;
            end
         end
      end
   end

   function automatic void put_pixel(int x, int y, bit set);
      int px, py, idx;
      logic [7:0] bitmask;
      if (x < 0 || y < 0) return;
      case (shadow_rot)
         ROT_0: begin
            if (x >= WIDTH || y >= HEIGHT) return;
            px = x; py = y;
         end
         ROT_90: begin
            if (x >= HEIGHT || y >= WIDTH) return;
            px = WIDTH - 1 - y; py = x;
         end
         ROT_180: begin
            if (x >= WIDTH || y >= HEIGHT) return;
            px = WIDTH - 1 - x; py = HEIGHT - 1 - y;
         end
         default: begin
            if (x >= HEIGHT || y >= WIDTH) return;
            px = y; py = HEIGHT - 1 - x;
         end
      endcase
      idx = (py / 8) * WIDTH + px;
      bitmask = 8'(1 << (py % 8));
      if (set && (shadow_fb[idx] & bitmask) == 0) begin
         shadow_fb[idx] |= bitmask;
         shadow_dirty[py / 8] = 1'b1;
      end else if (!set && (shadow_fb[idx] & bitmask) != 0) begin
         shadow_fb[idx] &= ~bitmask;
         shadow_dirty[py / 8] = 1'b1;
      end
   endfunction

   // Position along the minor axis, plus one half and truncated toward zero, done in exact integer form.
   function automatic int minor_pos(longint num, longint den, longint t, longint base);
      longint n, d;
      n = 2 * num * t + (2 * base + 1) * den;
      d = 2 * den;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      return int'(n / d);
   endfunction

   function automatic void draw_line(int x1, int y1, int x2, int y2, bit set);
      int dx, dy, adx, ady, step, k, i;
      dx = x2 - x1; dy = y2 - y1;
      adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
      if (dx == 0 && dy == 0) begin
         put_pixel(x1, y1, set);
         return;
      end
      if (adx > ady) begin
         step = dx > 0 ? 1 : -1;
         for (k = 0; k <= adx; k++) begin
            i = x1 + k * step;
            put_pixel(i, minor_pos(dy, dx, i - x1, y1), set);
         end
      end else begin
         step = dy > 0 ? 1 : -1;
         for (k = 0; k <= ady; k++) begin
            i = y1 + k * step;
            put_pixel(minor_pos(dx, dy, i - y1, x1), i, set);
         end
      end
   endfunction

   function automatic int lo_clip(int v);
      return v < 0 ? 0 : v;
   endfunction

   function automatic int hi_clip(int v);
      return v > VIEW_LIM - 1 ? VIEW_LIM - 1 : v;
   endfunction

   function automatic void draw_box(int x1, int y1, int x2, int y2, bit fill, bit set);
      int t, i, j;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      if (fill) begin
         for (i = lo_clip(x1); i <= hi_clip(x2); i++)
            for (j = lo_clip(y1); j <= hi_clip(y2); j++)
               put_pixel(i, j, set);
      end else begin
         for (i = lo_clip(x1); i <= hi_clip(x2); i++) begin
            put_pixel(i, y1, set);
            put_pixel(i, y2, set);
         end
         for (i = lo_clip(y1); i <= hi_clip(y2); i++) begin
            put_pixel(x1, i, set);
            put_pixel(x2, i, set);
         end
      end
   endfunction

   function automatic void mirror4(int a, int c, int i, int j, bit swap, bit set);
      if (!swap) begin
         put_pixel(a + i, c + j, set); put_pixel(a + i, c - j, set);
         put_pixel(a - i, c + j, set); put_pixel(a - i, c - j, set);
      end else begin
         put_pixel(c + j, a + i, set); put_pixel(c + j, a - i, set);
         put_pixel(c - j, a + i, set); put_pixel(c - j, a - i, set);
      end
   endfunction

   // Only spans of j that can land on screen are visited; repeats are harmless.
   function automatic void fill_span(int a, int c, int i, int jlim, bit swap, bit set);
      int lo, hi, j;
      if ((a + i < 0 || a + i >= VIEW_LIM) && (a - i < 0 || a - i >= VIEW_LIM)) return;
      lo = lo_clip(-c); hi = VIEW_LIM - 1 - c; if (hi > jlim) hi = jlim;
      for (j = lo; j <= hi; j++) mirror4(a, c, i, j, swap, set);
      lo = lo_clip(c - VIEW_LIM + 1); hi = c; if (hi > jlim) hi = jlim;
      for (j = lo; j <= hi; j++) mirror4(a, c, i, j, swap, set);
   endfunction

   function automatic void draw_ring(int x, int y, int r, bit fill, bit set);
      int i, v, s, b, jlim;
      for (i = 0; i * 100 <= r * 71; i++) begin
         v = r * r - i * i;
         s = 0;
         for (b = 4096; b > 0; b >>= 1)
            if ((s + b) * (s + b) <= v) s += b;
         jlim = (v - s * s > (s + 1) * (s + 1) - v) ? s + 1 : s;
         if (fill) begin
            fill_span(x, y, i, jlim, 1'b0, set);
            fill_span(y, x, i, jlim, 1'b1, set);
         end else begin
            mirror4(x, y, i, jlim, 1'b0, set);
            mirror4(y, x, i, jlim, 1'b1, set);
         end
      end
   endfunction

   function automatic readback_t render_cmd(draw_cmd_t c);
      readback_t res;
      res.read_byte = '0;
      res.dirty_mask = '0;
      case (c.mode)
         MODE_CLEAR: begin
            foreach (shadow_fb[k]) shadow_fb[k] = c.fill_byte;
            shadow_dirty = 8'hFF;
         end
         MODE_POINT:  put_pixel(c.xs, c.ys, c.color);
         MODE_LINE:   draw_line(c.xs, c.ys, c.xe, c.ye, c.color);
         MODE_RECT:   draw_box(c.xs, c.ys, c.xe, c.ye, c.fill, c.color);
         MODE_CIRCLE: draw_ring(c.xs, c.ys, int'(c.radius), c.fill, c.color);
         MODE_READ:   res.read_byte = shadow_fb[int'(c.page) * WIDTH + int'(c.column)];
         MODE_MASK: begin
            res.dirty_mask = shadow_dirty;
            shadow_dirty = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic draw_cmd_t mk(logic [2:0] mode, int xs, int ys, int xe, int ye,
                                    int radius, bit fill, bit color, int fb, int page,
                                    int column, bit known = 0, int kb = 0, int km = 0);
      draw_cmd_t c;
      c.mode = mode; c.xs = 16'(xs); c.ys = 16'(ys); c.xe = 16'(xe); c.ye = 16'(ye);
      c.radius = 12'(radius); c.fill = fill; c.color = color; c.fill_byte = 8'(fb);
      c.page = 3'(page); c.column = 7'(column);
      c.known = known; c.known_byte = 8'(kb); c.known_mask = 8'(km);
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_cmd(draw_cmd_t c);
      readback_t res;
      req_mode = c.mode; req_x_start = c.xs; req_y_start = c.ys;
      req_x_end = c.xe; req_y_end = c.ye; req_radius = c.radius;
      req_fill = c.fill; req_color = c.color; req_fill_byte = c.fill_byte;
      req_page = c.page; req_column = c.column;
      start = 1;
      while (busy) @(negedge clock);
      res = render_cmd(c);
      if (c.known) begin
         res.read_byte = c.known_byte;
         res.dirty_mask = c.known_mask;
      end
      readback_queue.push_back(res);
      @(negedge clock);
   endtask

   task automatic write_rotation(logic [1:0] rot);
      start = 0;
      while (readback_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
      csr_we = 1;
      csr_wdata = rot;
      @(negedge clock);
      csr_we = 0;
      shadow_rot = rot;
   endtask

   function automatic int any_coord();
      if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom)));
      return int'($urandom_range(0, 159)) - 16;
   endfunction

   function automatic int near_coord(int base, int span);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic draw_cmd_t random_cmd();
      int pick, xs, ys, r;
      bit fill;
      pick = $urandom_range(0, 99);
      xs = any_coord();
      ys = any_coord();
      fill = $urandom_range(0, 1);
      if (pick < 20)
         return mk(MODE_POINT, xs, ys, any_coord(), any_coord(), $urandom_range(0, 4095),
                   fill, $urandom_range(0, 1), $urandom_range(0, 255), 0, 0);
      if (pick < 45)
         return mk(MODE_LINE, xs, ys, near_coord(xs, 48), near_coord(ys, 48), 0, fill,
                   $urandom_range(0, 1), 0, 0, 0);
      if (pick < 60) begin
         // Filled boxes stay small; outlines may span anything.
         if (fill)
            return mk(MODE_RECT, near_coord(64, 80), near_coord(32, 50), near_coord(64, 80),
                      near_coord(32, 50), 0, 1'b1, $urandom_range(0, 1), 0, 0, 0);
         return mk(MODE_RECT, xs, ys, any_coord(), any_coord(), 0, 1'b0,
                   $urandom_range(0, 1), 0, 0, 0);
      end
      if (pick < 75) begin
         r = $urandom_range(0, 40);
         if (!fill && $urandom_range(0, 99) == 0) r = $urandom_range(0, 4095);
         return mk(MODE_CIRCLE, xs, ys, 0, 0, r, fill, $urandom_range(0, 1), 0, 0, 0);
      end
      if (pick < 87)
         return mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 7),
                   $urandom_range(0, 127));
      if (pick < 95)
         return mk(MODE_MASK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      if (pick < 98)
         return mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 255), 0, 0);
      return mk(3'd7, xs, ys, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0);
   endfunction

   initial begin
      draw_cmd_t directed[$];
      logic [1:0] phase_rot[4] = '{ROT_270, ROT_90, ROT_0, ROT_180};
      int idle_pct[4] = '{0, 53, 0, 19};
      foreach (shadow_fb[k]) shadow_fb[k] = '0;
      shadow_dirty = '0;
      shadow_rot = ROT_0;

      directed.push_back(mk(MODE_MASK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'hA5, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_MASK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 'hFF));
      directed.push_back(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7, 127, 1'b1, 'hA5, 0));
      directed.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'h5A, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 3, 64, 1'b1, 'h5A, 0));
      directed.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_POINT, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_POINT, 127, 63, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_POINT, -32768, -32768, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_POINT, 32767, 32767, 0, 0, 4095, 1, 1, 0, 0, 0));
      directed.push_back(mk(MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(MODE_LINE, 0, 0, 127, 63, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_LINE, 100, 2, 90, 60, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_LINE, 5, 5, 5, 5, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_LINE, -32768, -32768, -32760, -32765, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_LINE, 32767, 32767, 32760, 32767, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_RECT, 32767, 32767, -32768, -32768, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_RECT, 10, 20, 2, 3, 0, 1, 1, 0, 0, 0));
      directed.push_back(mk(MODE_CIRCLE, 64, 32, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_CIRCLE, 64, 32, 0, 0, 4095, 0, 1, 0, 0, 0));
      directed.push_back(mk(MODE_CIRCLE, 30, 30, 0, 0, 10, 1, 0, 0, 0, 0));
      directed.push_back(mk(3'd7, 1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1'b1, 0, 0));
      directed.push_back(mk(MODE_MASK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[k]) send_cmd(directed[k]);

      for (int ph = 0; ph < 4; ph++) begin
         write_rotation(phase_rot[ph]);
         for (int n = 0; n < 235; n++) begin
            if (idle_pct[ph] != 0 && $urandom_range(1, 100) <= idle_pct[ph]) begin
               start = 0;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end
            send_cmd(random_cmd());
         end
      end
      start = 0;

      while (readback_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
sv/pfde_pkg.sv
sv/pfde_ram.sv
sv/pfde_isqrt.sv
sv/pfde_plot_map.sv
sv/paged_framebuffer_draw_engine.sv
sv/pfde_checker.sv
bench/paged_framebuffer_draw_engine_test.sv
